[design/mmlp_pkg.sv]
// Shared types, constants and tables for the MML note sequencer parser.
package mmlp_pkg;

    localparam int MAX_NOTES = 64;

    // Numerator of the duration division (ms per whole note at tempo 1).
    localparam int DIV_BITS = 18;
    localparam logic [DIV_BITS-1:0] DUR_NUMERATOR = 18'd240000;

    localparam logic KIND_NOTE    = 1'b0;
    localparam logic KIND_SUMMARY = 1'b1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_LETTER = 2'd1;
    localparam logic [1:0] PH_LENGTH = 2'd2;
    localparam logic [1:0] PH_CMD    = 2'd3;

    localparam logic [2:0] PCMD_NONE   = 3'd0;
    localparam logic [2:0] PCMD_OCTAVE = 3'd1;
    localparam logic [2:0] PCMD_LENGTH = 3'd2;
    localparam logic [2:0] PCMD_TEMPO  = 3'd3;
    localparam logic [2:0] PCMD_VOICE  = 3'd4;

    typedef struct packed {
        logic [7:0] character;
        logic       end_of_string;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [12:0] frequency;
        logic [15:0] duration_ms;
        logic [1:0]  voice_number;
        logic        repeat_mode;
        logic        last;
    } out_item_t;

    typedef struct packed {
        logic capture;
        logic simple_step;
        logic start_note;
        logic div_step;
        logic load_note;
        logic post_byte;
        logic load_sum;
    } dp_cmd_t;

    typedef struct packed {
        logic eos;
        logic need_note;
        logic div_done;
        logic out_free;
    } dp_status_t;

    // Octave-4 frequencies of the twelve semitones, in hertz.
    function automatic logic [8:0] base_freq(input logic [3:0] semi);
        logic [8:0] f;
        begin
            unique case (semi)
                4'd0:    f = 9'd262;
                4'd1:    f = 9'd277;
                4'd2:    f = 9'd294;
                4'd3:    f = 9'd311;
                4'd4:    f = 9'd330;
                4'd5:    f = 9'd349;
                4'd6:    f = 9'd370;
                4'd7:    f = 9'd392;
                4'd8:    f = 9'd415;
                4'd9:    f = 9'd440;
                4'd10:   f = 9'd466;
                4'd11:   f = 9'd494;
                default: f = 9'd262;
            endcase
            return f;
        end
    endfunction

endpackage

[design/mmlp_ctrl.sv]
// Controller state machine of the MML parser: sequences decode, divide and result loads.
module mmlp_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 in_ready,
    input  mmlp_pkg::dp_status_t status,
    output mmlp_pkg::dp_cmd_t    cmd
);
    import mmlp_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_DECODE = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_NOTE   = 3'd3;
    localparam logic [2:0] ST_POST   = 3'd4;
    localparam logic [2:0] ST_SUM    = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (status.need_note) begin
                    cmd.start_note = 1'b1;
                    state_next = ST_DIV;
                end else if (status.eos) begin
                    state_next = ST_SUM;
                end else begin
                    cmd.simple_step = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_NOTE;
                end else begin
                    cmd.div_step = 1'b1;
                end
            end
            ST_NOTE: begin
                if (status.out_free) begin
                    cmd.load_note = 1'b1;
                    state_next = ST_POST;
                end
            end
            ST_POST: begin
                if (status.eos) begin
                    state_next = ST_SUM;
                end else begin
                    cmd.post_byte = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_SUM: begin
                if (status.out_free) begin
                    cmd.load_sum = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

[design/mmlp_dp.sv]
// Datapath of the MML parser: parse state, duration divider and output register.
module mmlp_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mmlp_pkg::in_item_t   s_data,
    input  mmlp_pkg::dp_cmd_t    cmd,
    output mmlp_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mmlp_pkg::out_item_t  m_data
);
    import mmlp_pkg::*;

    logic [7:0]          char_reg, char_next;
    logic                eos_reg, eos_next;
    logic [1:0]          phase_reg, phase_next;
    logic [3:0]          octave_reg, octave_next;
    logic [15:0]         dflt_len_reg, dflt_len_next;
    logic [15:0]         tempo_reg, tempo_next;
    logic [1:0]          voice_reg, voice_next;
    logic                repeat_reg, repeat_next;
    logic [7:0]          count_reg, count_next;
    logic [15:0]         accum_reg, accum_next;
    logic                has_digits_reg, has_digits_next;
    logic [3:0]          semi_reg, semi_next;
    logic                is_rest_reg, is_rest_next;
    logic [2:0]          pcmd_reg, pcmd_next;
    logic                stopped_reg, stopped_next;
    logic                dotted_reg, dotted_next;
    logic [31:0]         prod_reg, prod_next;
    logic [DIV_BITS-1:0] num_reg, num_next;
    logic [DIV_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0] quo_reg, quo_next;
    logic [4:0]          div_cnt_reg, div_cnt_next;
    logic                m_valid_reg, m_valid_next;
    out_item_t           m_data_reg, m_data_next;

    logic [7:0]  lc;
    logic        is_digit;
    logic        in_note;
    logic        acc_up, acc_down;
    logic [19:0] acc_sum;
    logic [15:0] acc_sat;
    logic [3:0]  oct_ap;
    logic [15:0] len_ap, tempo_ap;
    logic [1:0]  voice_ap;
    logic [3:0]  oct_base;
    logic        letter_hit;
    logic [3:0]  letter_semi;
    logic        do_idle;
    logic [15:0] len_eff, tempo_eff;
    logic [DIV_BITS:0] trial;
    logic        trial_ge;
    logic [15:0] dur;
    logic [3:0]  oct_clamp;
    logic [12:0] base13, freq;
    logic [7:0]  count_inc;

    assign lc       = char_reg | 8'h20;
    assign is_digit = (char_reg >= "0") && (char_reg <= "9");
    assign in_note  = (phase_reg == PH_LETTER) || (phase_reg == PH_LENGTH);
    assign acc_up   = (phase_reg == PH_LETTER) && (char_reg == "#" || char_reg == "+");
    assign acc_down = (phase_reg == PH_LETTER) && (char_reg == "-");

    // Decimal accumulate with saturation at the top of the 16-bit range.
    assign acc_sum = {1'b0, accum_reg, 3'b000} + {3'b000, accum_reg, 1'b0}
                   + {16'd0, char_reg[3:0]};
    assign acc_sat = (acc_sum > 20'd65535) ? 16'hFFFF : acc_sum[15:0];

    // Command values as they would be after the pending command is applied.
    always_comb begin
        oct_ap   = octave_reg;
        len_ap   = dflt_len_reg;
        tempo_ap = tempo_reg;
        voice_ap = voice_reg;
        if (has_digits_reg) begin
            unique case (pcmd_reg)
                PCMD_OCTAVE: if (accum_reg >= 16'd1 && accum_reg <= 16'd8) oct_ap = accum_reg[3:0];
                PCMD_LENGTH: if (accum_reg != 16'd0) len_ap = accum_reg;
                PCMD_TEMPO:  if (accum_reg != 16'd0) tempo_ap = accum_reg;
                PCMD_VOICE:  if (accum_reg <= 16'd2) voice_ap = accum_reg[1:0];
                default: begin
                end
            endcase
        end
    end

    assign oct_base = (phase_reg == PH_CMD) ? oct_ap : octave_reg;

    always_comb begin
        letter_hit  = 1'b1;
        letter_semi = 4'd0;
        unique case (lc)
            "c":     letter_semi = 4'd0;
            "d":     letter_semi = 4'd2;
            "e":     letter_semi = 4'd4;
            "f":     letter_semi = 4'd5;
            "g":     letter_semi = 4'd7;
            "a":     letter_semi = 4'd9;
            "b":     letter_semi = 4'd11;
            default: letter_hit = 1'b0;
        endcase
    end

    assign status.eos       = eos_reg;
    assign status.need_note = !stopped_reg && in_note
                            && (eos_reg || !(is_digit || acc_up || acc_down));
    assign status.div_done  = (div_cnt_reg == 5'(DIV_BITS));
    assign status.out_free  = !m_valid_reg || m_ready;

    assign do_idle = (cmd.simple_step && !stopped_reg && !acc_up && !acc_down
                      && !is_digit)
                   || (cmd.post_byte && !dotted_reg && !stopped_reg);

    assign len_eff   = (has_digits_reg && accum_reg != 16'd0) ? accum_reg
                     : ((dflt_len_reg != 16'd0) ? dflt_len_reg : 16'd1);
    assign tempo_eff = (tempo_reg != 16'd0) ? tempo_reg : 16'd1;

    // One restoring step of the quotient per cycle.
    assign trial    = {rem_reg, num_reg[DIV_BITS-1]};
    assign trial_ge = {13'd0, trial} >= prod_reg;

    assign dur = dotted_reg ? (quo_reg[15:0] + {1'b0, quo_reg[15:1]}) : quo_reg[15:0];

    assign oct_clamp = (octave_reg < 4'd1) ? 4'd1 : ((octave_reg > 4'd8) ? 4'd8 : octave_reg);
    assign base13    = {4'd0, base_freq(semi_reg)};

    always_comb begin
        unique case (oct_clamp)
            4'd1:    freq = base13 >> 3;
            4'd2:    freq = base13 >> 2;
            4'd3:    freq = base13 >> 1;
            4'd5:    freq = base13 << 1;
            4'd6:    freq = base13 << 2;
            4'd7:    freq = base13 << 3;
            4'd8:    freq = base13 << 4;
            default: freq = base13;
        endcase
    end

    assign count_inc = count_reg + 8'd1;

    always_comb begin
        char_next       = char_reg;
        eos_next        = eos_reg;
        phase_next      = phase_reg;
        octave_next     = octave_reg;
        dflt_len_next   = dflt_len_reg;
        tempo_next      = tempo_reg;
        voice_next      = voice_reg;
        repeat_next     = repeat_reg;
        count_next      = count_reg;
        accum_next      = accum_reg;
        has_digits_next = has_digits_reg;
        semi_next       = semi_reg;
        is_rest_next    = is_rest_reg;
        pcmd_next       = pcmd_reg;
        stopped_next    = stopped_reg;
        dotted_next     = dotted_reg;
        prod_next       = prod_reg;
        num_next        = num_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        div_cnt_next    = div_cnt_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        if (cmd.capture) begin
            char_next = s_data.character;
            eos_next  = s_data.end_of_string;
        end

        if (cmd.simple_step && !stopped_reg) begin
            if (acc_up) begin
                if (semi_reg >= 4'd11) begin
                    semi_next = 4'd0;
                    if (octave_reg < 4'd9) octave_next = octave_reg + 4'd1;
                end else begin
                    semi_next = semi_reg + 4'd1;
                end
                phase_next = PH_LENGTH;
            end else if (acc_down) begin
                if (semi_reg == 4'd0) begin
                    semi_next = 4'd11;
                    if (octave_reg > 4'd0) octave_next = octave_reg - 4'd1;
                end else begin
                    semi_next = semi_reg - 4'd1;
                end
                phase_next = PH_LENGTH;
            end else if (is_digit) begin
                accum_next      = acc_sat;
                has_digits_next = 1'b1;
                if (in_note) phase_next = PH_LENGTH;
            end else if (phase_reg == PH_CMD) begin
                octave_next   = oct_ap;
                dflt_len_next = len_ap;
                tempo_next    = tempo_ap;
                voice_next    = voice_ap;
                phase_next    = PH_IDLE;
            end
        end

        // A byte outside a note, or the byte that ended a note or command, starts something new.
        if (do_idle) begin
            if (letter_hit) begin
                semi_next       = letter_semi;
                is_rest_next    = 1'b0;
                accum_next      = 16'd0;
                has_digits_next = 1'b0;
                phase_next      = PH_LETTER;
            end else if (lc == "r" || lc == "p") begin
                semi_next       = 4'd0;
                is_rest_next    = 1'b1;
                accum_next      = 16'd0;
                has_digits_next = 1'b0;
                phase_next      = PH_LENGTH;
            end else if (lc == "o" || lc == "l" || lc == "t" || lc == "v") begin
                priority case (lc)
                    "o":     pcmd_next = PCMD_OCTAVE;
                    "l":     pcmd_next = PCMD_LENGTH;
                    "t":     pcmd_next = PCMD_TEMPO;
                    default: pcmd_next = PCMD_VOICE;
                endcase
                accum_next      = 16'd0;
                has_digits_next = 1'b0;
                phase_next      = PH_CMD;
            end else if (char_reg == ">") begin
                if (oct_base < 4'd8) octave_next = oct_base + 4'd1;
            end else if (char_reg == "<") begin
                if (oct_base > 4'd1) octave_next = oct_base - 4'd1;
            end else if (char_reg == "!") begin
                repeat_next = 1'b1;
            end
        end

        if (cmd.start_note) begin
            prod_next    = tempo_eff * len_eff;
            num_next     = DUR_NUMERATOR;
            rem_next     = '0;
            quo_next     = '0;
            div_cnt_next = 5'd0;
            dotted_next  = !eos_reg && (char_reg == ".");
        end

        if (cmd.div_step) begin
            num_next     = {num_reg[DIV_BITS-2:0], 1'b0};
            quo_next     = {quo_reg[DIV_BITS-2:0], trial_ge};
            rem_next     = trial_ge ? DIV_BITS'({13'd0, trial} - prod_reg)
                                    : trial[DIV_BITS-1:0];
            div_cnt_next = div_cnt_reg + 5'd1;
        end

        if (cmd.load_note) begin
            m_valid_next             = 1'b1;
            m_data_next.kind         = KIND_NOTE;
            m_data_next.frequency    = is_rest_reg ? 13'd0 : freq;
            m_data_next.duration_ms  = dur;
            m_data_next.voice_number = 2'd0;
            m_data_next.repeat_mode  = 1'b0;
            m_data_next.last         = 1'b0;
            count_next               = count_inc;
            if (count_inc >= 8'(MAX_NOTES)) stopped_next = 1'b1;
            phase_next               = PH_IDLE;
        end

        if (cmd.load_sum) begin
            m_valid_next             = 1'b1;
            m_data_next.kind         = KIND_SUMMARY;
            m_data_next.frequency    = 13'd0;
            m_data_next.duration_ms  = 16'd0;
            m_data_next.voice_number = (phase_reg == PH_CMD && !stopped_reg) ? voice_ap
                                                                             : voice_reg;
            m_data_next.repeat_mode  = repeat_reg;
            m_data_next.last         = 1'b1;
            phase_next      = PH_IDLE;
            octave_next     = 4'd4;
            dflt_len_next   = 16'd4;
            tempo_next      = 16'd120;
            voice_next      = 2'd0;
            repeat_next     = 1'b0;
            count_next      = 8'd0;
            accum_next      = 16'd0;
            has_digits_next = 1'b0;
            semi_next       = 4'd0;
            is_rest_next    = 1'b0;
            pcmd_next       = PCMD_NONE;
            stopped_next    = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eos_reg        <= 1'b0;
            phase_reg      <= PH_IDLE;
            octave_reg     <= 4'd4;
            dflt_len_reg   <= 16'd4;
            tempo_reg      <= 16'd120;
            voice_reg      <= 2'd0;
            repeat_reg     <= 1'b0;
            count_reg      <= 8'd0;
            accum_reg      <= 16'd0;
            has_digits_reg <= 1'b0;
            semi_reg       <= 4'd0;
            is_rest_reg    <= 1'b0;
            pcmd_reg       <= PCMD_NONE;
            stopped_reg    <= 1'b0;
            dotted_reg     <= 1'b0;
            div_cnt_reg    <= 5'd0;
            m_valid_reg    <= 1'b0;
        end else begin
            eos_reg        <= eos_next;
            phase_reg      <= phase_next;
            octave_reg     <= octave_next;
            dflt_len_reg   <= dflt_len_next;
            tempo_reg      <= tempo_next;
            voice_reg      <= voice_next;
            repeat_reg     <= repeat_next;
            count_reg      <= count_next;
            accum_reg      <= accum_next;
            has_digits_reg <= has_digits_next;
            semi_reg       <= semi_next;
            is_rest_reg    <= is_rest_next;
            pcmd_reg       <= pcmd_next;
            stopped_reg    <= stopped_next;
            dotted_reg     <= dotted_next;
            div_cnt_reg    <= div_cnt_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        char_reg   <= char_next;
        prod_reg   <= prod_next;
        num_reg    <= num_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[design/mml_note_sequencer_parser.sv]
// Top level of the MML note sequencer parser: controller plus datapath.
//
//  channel | direction | handshake          | payload
//  s_      | in        | s_valid / s_ready  | s_data  (character, end_of_string)
//  m_      | out       | m_valid / m_ready  | m_data  (kind, frequency, duration_ms,
//          |           |                    |          voice_number, repeat_mode, last)
//
// A character that completes no note passes through accept and decode.
// A character that completes a note passes through accept, decode with the 16x16 product,
// 18 restoring divider steps, the exit from the divider, the load once the output register
// is free, and the ending byte. End of string adds the summary transaction.
// Reset is synchronous and active low; all parser settings return to their defaults.
// A waiting result lets the next character in; only a new load into it stalls the parser.
module mml_note_sequencer_parser (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  mmlp_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output mmlp_pkg::out_item_t m_data
);
    import mmlp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    mmlp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .in_ready (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    mmlp_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

[design/mmlp_chk.sv]
// Port-level checker for the MML parser, bound to the top level.
module mmlp_chk (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input mmlp_pkg::out_item_t m_data
);
    import mmlp_pkg::*;

    // A stalled result transaction keeps its payload.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    // Only the summary closes a string.
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.last == m_data.kind))
        else $error("last flag does not match kind");

    a_note: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_NOTE |->
            m_data.voice_number == 2'd0 && m_data.repeat_mode == 1'b0)
        else $error("note carries summary fields");

    a_sum: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind == KIND_SUMMARY |->
            m_data.frequency == 13'd0 && m_data.duration_ms == 16'd0
            && m_data.voice_number != 2'd3)
        else $error("summary carries note fields");

    a_rst: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind mml_note_sequencer_parser mmlp_chk u_mmlp_chk (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
